// File: rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Status codes, register indexes, reset values and the result record.
// ----------------------------------------------------------------------------
package uer_pkg;

    typedef enum logic [1:0] {
        STATUS_NONE    = 2'd0,
        STATUS_VALID   = 2'd1,
        STATUS_RANGE   = 2'd2,
        STATUS_NO_ECHO = 2'd3
    } uer_status_t;

    localparam logic [1:0] REG_FIRING_INTERVAL = 2'd0;
    localparam logic [1:0] REG_MAX_RANGE       = 2'd1;
    localparam logic [1:0] REG_TRIGGER_WIDTH   = 2'd2;

    localparam int unsigned INTERVAL_W = 20;
    localparam int unsigned RANGE_W    = 10;
    localparam int unsigned TRIG_W     = 8;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CFG_DATA_W = 20;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 20'd60000;
    localparam logic [RANGE_W-1:0]    RANGE_RESET    = 10'd400;
    localparam logic [TRIG_W-1:0]     TRIG_RESET     = 8'd11;

    // Ticks per centimetre of round trip.
    localparam logic [5:0]  CM_DIVISOR  = 6'd59;
    localparam logic [5:0]  CM_REM_LAST = 6'd58;
    // Quotient saturates here; anything at or above is beyond any range limit.
    localparam logic [10:0] QUOT_SAT    = 11'd1024;

    typedef struct packed {
        logic                trigger_level;
        logic                read_valid;
        logic [RANGE_W-1:0]  distance_cm;
        uer_status_t         reading_status;
    } uer_result_t;

endpackage

// File: rtl/ultrasonic_echo_ranger_core.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger core
// Trigger generation, echo timing and distance reporting per microsecond tick.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one transaction per
//   microsecond tick: the sampled echo level and a read strobe. Every input
//   transaction yields exactly one output transaction (out_valid / out_stall)
//   with the trigger drive level and, on a read, the latched distance/status.
//   One transaction is accepted per cycle while in_stall is low. The division
//   by 59 is kept as a running quotient and remainder that advance with each
//   tick, so no divider sits in the path. When the receiver stalls, one result
//   waits in the output register and a second in a skid register; in_stall
//   rises only once the skid is full. The user writes configuration
//   (cfg_write / cfg_index / cfg_data) only while idle; the core does not
//   enforce it. Reset: tick counts clear, the held status is out of range, and
//   the registers take 60000 us interval, 400 cm limit and 11 us trigger width.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_core
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        echo_level,
    input  logic        read_request,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        trigger_level,
    output logic        read_valid,
    output logic [9:0]  distance_cm,
    output logic [1:0]  reading_status,
    // configuration
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    logic [uer_pkg::INTERVAL_W-1:0] firing_interval_reg;
    logic [uer_pkg::RANGE_W-1:0]    max_range_reg;
    logic [uer_pkg::TRIG_W-1:0]     trigger_width_reg;

    logic [uer_pkg::TIME_W-1:0]     elapsed_reg, elapsed_next;
    logic [uer_pkg::TIME_W-1:0]     echo_width_reg, echo_width_next;
    logic [10:0]                    quot_reg, quot_next;
    logic [5:0]                     rem_reg, rem_next;
    logic                           echo_prev_reg;
    logic [uer_pkg::TRIG_W-1:0]     trig_remaining_reg, trig_remaining_next;
    logic                           awaiting_reg, awaiting_next;
    logic [uer_pkg::RANGE_W-1:0]    held_distance_reg, held_distance_next;
    uer_pkg::uer_status_t           held_status_reg, held_status_next;

    uer_pkg::uer_result_t           result;
    uer_pkg::uer_result_t           out_data_reg, skid_data_reg;
    logic                           out_valid_reg, skid_valid_reg;

    logic                           accept;
    logic                           rising, falling, window_over, capture;
    logic                           awaiting_mid;
    logic [uer_pkg::TRIG_W-1:0]     trig_eff;
    uer_pkg::uer_status_t           status_mid;

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid & ~in_stall;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            firing_interval_reg <= uer_pkg::INTERVAL_RESET;
            max_range_reg       <= uer_pkg::RANGE_RESET;
            trigger_width_reg   <= uer_pkg::TRIG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                uer_pkg::REG_FIRING_INTERVAL:
                    firing_interval_reg <= cfg_data[uer_pkg::INTERVAL_W-1:0];
                uer_pkg::REG_MAX_RANGE:
                    max_range_reg <= cfg_data[uer_pkg::RANGE_W-1:0];
                uer_pkg::REG_TRIGGER_WIDTH:
                    trigger_width_reg <= cfg_data[uer_pkg::TRIG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Per-tick logic
    // ------------------------------------------------------------------
    always_comb
    begin
        rising      = echo_level & ~echo_prev_reg;
        falling     = ~echo_level & echo_prev_reg;
        window_over = elapsed_reg > {12'd0, firing_interval_reg};
        capture     = falling & awaiting_reg & (echo_width_reg != '0) & ~window_over;

        // elapsed since trigger; restarts at one after a new trigger
        elapsed_next = window_over ? 32'd1 : elapsed_reg + 32'd1;

        // echo width with running width / 59; quotient saturated, width clears at all ones
        if (rising)
        begin
            echo_width_next = 32'd1;
            quot_next       = 11'd0;
            rem_next        = 6'd1;
        end
        else if (echo_width_reg == '1)
        begin
            echo_width_next = '0;
            quot_next       = 11'd0;
            rem_next        = 6'd0;
        end
        else
        begin
            echo_width_next = echo_width_reg + 32'd1;
            if (rem_reg == uer_pkg::CM_REM_LAST)
            begin
                rem_next  = 6'd0;
                quot_next = (quot_reg == uer_pkg::QUOT_SAT) ? quot_reg : quot_reg + 11'd1;
            end
            else
            begin
                rem_next  = rem_reg + 6'd1;
                quot_next = quot_reg;
            end
        end

        status_mid         = held_status_reg;
        held_distance_next = held_distance_reg;
        awaiting_mid       = awaiting_reg;
        if (capture)
        begin
            awaiting_mid = 1'b0;
            if (quot_reg > {1'b0, max_range_reg})
            begin
                status_mid = uer_pkg::STATUS_RANGE;
            end
            else
            begin
                status_mid         = uer_pkg::STATUS_VALID;
                held_distance_next = quot_reg[uer_pkg::RANGE_W-1:0];
            end
        end

        awaiting_next = awaiting_mid;
        trig_eff      = trig_remaining_reg;
        if (window_over)
        begin
            if (awaiting_mid)
            begin
                status_mid = uer_pkg::STATUS_NO_ECHO;
            end
            awaiting_next = 1'b1;
            trig_eff      = trigger_width_reg;
        end

        result.trigger_level = (trig_eff != '0);
        trig_remaining_next  = (trig_eff != '0) ? trig_eff - 8'd1 : '0;

        result.read_valid = read_request;
        if (read_request)
        begin
            result.reading_status = status_mid;
            result.distance_cm    = (status_mid == uer_pkg::STATUS_VALID) ?
                                    held_distance_next : '0;
            held_status_next      = uer_pkg::STATUS_NONE;
        end
        else
        begin
            result.reading_status = uer_pkg::STATUS_NONE;
            result.distance_cm    = '0;
            held_status_next      = status_mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg        <= '0;
            echo_width_reg     <= '0;
            quot_reg           <= '0;
            rem_reg            <= '0;
            echo_prev_reg      <= 1'b0;
            trig_remaining_reg <= '0;
            awaiting_reg       <= 1'b0;
            held_distance_reg  <= '0;
            held_status_reg    <= uer_pkg::STATUS_RANGE;
        end
        else if (accept)
        begin
            elapsed_reg        <= elapsed_next;
            echo_width_reg     <= echo_width_next;
            quot_reg           <= quot_next;
            rem_reg            <= rem_next;
            echo_prev_reg      <= echo_level;
            trig_remaining_reg <= trig_remaining_next;
            awaiting_reg       <= awaiting_next;
            held_distance_reg  <= held_distance_next;
            held_status_reg    <= held_status_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register with skid stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || !out_stall)
            begin
                out_valid_reg  <= skid_valid_reg | accept;
                skid_valid_reg <= 1'b0;
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        end
        else if (accept)
        begin
            skid_data_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign trigger_level  = out_data_reg.trigger_level;
    assign read_valid     = out_data_reg.read_valid;
    assign distance_cm    = out_data_reg.distance_cm;
    assign reading_status = out_data_reg.reading_status;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds data while output register is empty");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg < uer_pkg::CM_DIVISOR && quot_reg <= uer_pkg::QUOT_SAT)
        else $error("running quotient out of bounds");

    a_dist_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && distance_cm != '0) |->
            (read_valid && reading_status == uer_pkg::STATUS_VALID))
        else $error("distance reported without valid status");

    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && read_request) |=> (held_status_reg == uer_pkg::STATUS_NONE))
        else $error("held status not cleared after read");

endmodule
